@@ hdl/htba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htba_pkg
// Shared types and constants of the heading to binary angle converter: the
// per-transaction control word and the sine and cosine bin boundary tables.
// ----------------------------------------------------------------------------
package htba_pkg;

   localparam int DEFAULT_COORD_WIDTH = 16;
   localparam int BIN_COUNT           = 32;
   localparam int CELL_COUNT          = BIN_COUNT - 1;
   localparam int BIN_W               = $clog2(BIN_COUNT);
   localparam int TAB_W               = 64;
   localparam int CONST_LO_W          = 32;
   localparam int CONST_HI_W          = 31;

   localparam logic [7:0] HEADING_POS_Z = 8'd64;
   localparam logic [7:0] HEADING_NEG_Z = 8'd192;
   localparam logic [7:0] HALF_TURN     = 8'd128;
   localparam logic [7:0] HALF_TURN_M1  = 8'd127;
   localparam logic [5:0] QUADRANT_MAX  = 6'd63;
   localparam logic [5:0] OCTANT_EDGE   = 6'd32;

   localparam logic [TAB_W-1:0] ONE_Q = 64'h4000_0000_0000_0000;

   typedef logic [TAB_W-1:0] tab_type [BIN_COUNT];

   typedef struct packed {
      logic             xzero;
      logic             zpos;
      logic             xneg;
      logic             zneg;
      logic             swapped;
      logic             exact;
      logic             equal;
      logic             done;
      logic [BIN_W-1:0] bin;
   } ctrl_type;

   function automatic logic [TAB_W-1:0] sqrt_q(input logic [TAB_W-1:0] v);
      logic [127:0]     n;
      logic [127:0]     p;
      logic [TAB_W-1:0] r;
      logic [TAB_W-1:0] t;
      n = {64'b0, v} << 62;
      r = '0;
      for (int idx = 62; idx >= 0; idx--) begin
         t = r | (64'd1 << idx);
         p = {64'b0, t} * {64'b0, t};
         if (p <= n) begin
            r = t;
         end
      end
      return r;
   endfunction

   function automatic logic [TAB_W-1:0] mul_q(input logic [TAB_W-1:0] a,
                                              input logic [TAB_W-1:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[125:62] + {63'b0, p[61]};
   endfunction

   function automatic tab_type build_tab(input logic want_sin);
      tab_type          ct;
      tab_type          st;
      logic [TAB_W-1:0] c;
      logic [TAB_W-1:0] c1;
      logic [TAB_W-1:0] s1;
      c = '0;
      for (int i = 0; i < 5; i++) begin
         c = sqrt_q((ONE_Q + c) >> 1);
      end
      c1 = sqrt_q((ONE_Q + c) >> 1);
      s1 = sqrt_q((ONE_Q - c) >> 1);
      ct[0] = ONE_Q;
      st[0] = '0;
      ct[1] = c1;
      st[1] = s1;
      for (int i = 2; i < BIN_COUNT; i++) begin
         ct[i] = mul_q(ct[i-1], c1) - mul_q(st[i-1], s1);
         st[i] = mul_q(st[i-1], c1) + mul_q(ct[i-1], s1);
      end
      return want_sin ? st : ct;
   endfunction

   localparam tab_type COS_TAB = build_tab(1'b0);
   localparam tab_type SIN_TAB = build_tab(1'b1);

endpackage

@@ hdl/htba_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htba_front
// Input stage: split both coordinates into sign and magnitude, order the
// magnitudes into the first octant and record the special cases.
// ----------------------------------------------------------------------------
module htba_front #(
   parameter int COORD_WIDTH = htba_pkg::DEFAULT_COORD_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [COORD_WIDTH-1:0] x_coord,
   input  logic [COORD_WIDTH-1:0] z_coord,
   output logic                   out_valid,
   output htba_pkg::ctrl_type     out_ctrl,
   output logic [COORD_WIDTH-1:0] out_a,
   output logic [COORD_WIDTH-1:0] out_b
);
   import htba_pkg::*;

   logic                   valid_ff;
   ctrl_type               ctrl_ff;
   ctrl_type               ctrl_in;
   logic [COORD_WIDTH-1:0] a_ff;
   logic [COORD_WIDTH-1:0] a_in;
   logic [COORD_WIDTH-1:0] b_ff;
   logic [COORD_WIDTH-1:0] b_in;
   logic [COORD_WIDTH-1:0] u_mag;
   logic [COORD_WIDTH-1:0] w_mag;

   always_comb begin
      u_mag = x_coord[COORD_WIDTH-1] ? (~x_coord + 1'b1) : x_coord;
      w_mag = z_coord[COORD_WIDTH-1] ? (~z_coord + 1'b1) : z_coord;
      ctrl_in         = '0;
      ctrl_in.xzero   = (u_mag == '0);
      ctrl_in.zpos    = !z_coord[COORD_WIDTH-1] && (w_mag != '0);
      ctrl_in.xneg    = x_coord[COORD_WIDTH-1];
      ctrl_in.zneg    = z_coord[COORD_WIDTH-1];
      ctrl_in.swapped = (w_mag > u_mag);
      ctrl_in.exact   = (w_mag == '0) || (w_mag == u_mag);
      ctrl_in.equal   = (w_mag == u_mag);
      a_in = ctrl_in.swapped ? u_mag : w_mag;
      b_in = ctrl_in.swapped ? w_mag : u_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff <= ctrl_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;

endmodule

@@ hdl/htba_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htba_cell
// One bin boundary of the octant search: multiply the ordered magnitudes by
// the boundary's cosine and sine, then compare the cross products and
// advance the bin count while the vector lies at or above the boundary.
// ----------------------------------------------------------------------------
module htba_cell #(
   parameter int COORD_WIDTH = htba_pkg::DEFAULT_COORD_WIDTH,
   parameter int BIN_INDEX   = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  htba_pkg::ctrl_type     in_ctrl,
   input  logic [COORD_WIDTH-1:0] in_a,
   input  logic [COORD_WIDTH-1:0] in_b,
   output logic                   out_valid,
   output htba_pkg::ctrl_type     out_ctrl,
   output logic [COORD_WIDTH-1:0] out_a,
   output logic [COORD_WIDTH-1:0] out_b
);
   import htba_pkg::*;

   localparam int PP_W   = COORD_WIDTH + CONST_LO_W;
   localparam int PROD_W = COORD_WIDTH + CONST_LO_W + CONST_HI_W;

   localparam logic [TAB_W-1:0]      COS_K  = COS_TAB[BIN_INDEX];
   localparam logic [TAB_W-1:0]      SIN_K  = SIN_TAB[BIN_INDEX];
   localparam logic [CONST_LO_W-1:0] COS_LO = COS_K[CONST_LO_W-1:0];
   localparam logic [CONST_HI_W-1:0] COS_HI = COS_K[CONST_LO_W+CONST_HI_W-1:CONST_LO_W];
   localparam logic [CONST_LO_W-1:0] SIN_LO = SIN_K[CONST_LO_W-1:0];
   localparam logic [CONST_HI_W-1:0] SIN_HI = SIN_K[CONST_LO_W+CONST_HI_W-1:CONST_LO_W];

   logic                   mul_valid_ff;
   ctrl_type               mul_ctrl_ff;
   logic [COORD_WIDTH-1:0] mul_a_ff;
   logic [COORD_WIDTH-1:0] mul_b_ff;
   logic [PP_W-1:0]        pa_lo_ff;
   logic [PP_W-1:0]        pa_lo_in;
   logic [PP_W-1:0]        pa_hi_ff;
   logic [PP_W-1:0]        pa_hi_in;
   logic [PP_W-1:0]        pb_lo_ff;
   logic [PP_W-1:0]        pb_lo_in;
   logic [PP_W-1:0]        pb_hi_ff;
   logic [PP_W-1:0]        pb_hi_in;

   logic                   cmp_valid_ff;
   ctrl_type               cmp_ctrl_ff;
   ctrl_type               cmp_ctrl_in;
   logic [COORD_WIDTH-1:0] cmp_a_ff;
   logic [COORD_WIDTH-1:0] cmp_b_ff;
   logic [PROD_W-1:0]      lhs;
   logic [PROD_W-1:0]      rhs;

   assign pa_lo_in = PP_W'(in_a) * PP_W'(COS_LO);
   assign pa_hi_in = PP_W'(in_a) * PP_W'(COS_HI);
   assign pb_lo_in = PP_W'(in_b) * PP_W'(SIN_LO);
   assign pb_hi_in = PP_W'(in_b) * PP_W'(SIN_HI);

   always_comb begin
      lhs = (PROD_W'(pa_hi_ff) << CONST_LO_W) + PROD_W'(pa_lo_ff);
      rhs = (PROD_W'(pb_hi_ff) << CONST_LO_W) + PROD_W'(pb_lo_ff);
      cmp_ctrl_in = mul_ctrl_ff;
      if (!mul_ctrl_ff.done) begin
         if (lhs >= rhs) begin
            cmp_ctrl_in.bin = BIN_W'(BIN_INDEX);
         end else begin
            cmp_ctrl_in.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
         cmp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ctrl_ff <= in_ctrl;
         mul_a_ff    <= in_a;
         mul_b_ff    <= in_b;
         pa_lo_ff    <= pa_lo_in;
         pa_hi_ff    <= pa_hi_in;
         pb_lo_ff    <= pb_lo_in;
         pb_hi_ff    <= pb_hi_in;
         cmp_ctrl_ff <= cmp_ctrl_in;
         cmp_a_ff    <= mul_a_ff;
         cmp_b_ff    <= mul_b_ff;
      end
   end

   assign out_valid = cmp_valid_ff;
   assign out_ctrl  = cmp_ctrl_ff;
   assign out_a     = cmp_a_ff;
   assign out_b     = cmp_b_ff;

endmodule

@@ hdl/htba_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htba_back
// Output stage: unfold the octant bin into a full-turn heading, then hold
// it in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module htba_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  htba_pkg::ctrl_type in_ctrl,
   output logic               advance,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata
);
   import htba_pkg::*;

   logic       fold_valid_ff;
   logic [7:0] fold_heading_ff;
   logic [7:0] fold_heading_in;
   logic       out_valid_ff;
   logic [7:0] out_heading_ff;
   logic       skid_valid_ff;
   logic [7:0] skid_heading_ff;
   logic       take;
   logic [5:0] oct;
   logic [5:0] quad;
   logic [7:0] half;

   always_comb begin
      oct  = in_ctrl.equal ? OCTANT_EDGE : {1'b0, in_ctrl.bin};
      quad = in_ctrl.swapped ? (QUADRANT_MAX - oct) : oct;
      if (in_ctrl.xneg) begin
         half = (in_ctrl.exact ? HALF_TURN : HALF_TURN_M1) - {2'b0, quad};
      end else begin
         half = {2'b0, quad};
      end
      if (in_ctrl.xzero) begin
         fold_heading_in = in_ctrl.zpos ? HEADING_POS_Z : HEADING_NEG_Z;
      end else begin
         fold_heading_in = in_ctrl.zneg ? (8'd0 - half) : half;
      end
   end

   assign advance = !skid_valid_ff;
   assign take    = rsp_tready || !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_heading_ff <= fold_heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (fold_valid_ff) begin
         if (take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_heading_ff <= skid_heading_ff;
         end
      end else if (fold_valid_ff) begin
         if (take) begin
            out_heading_ff <= fold_heading_ff;
         end else begin
            skid_heading_ff <= fold_heading_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_heading_ff;

endmodule

@@ hdl/heading_to_binary_angle.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_to_binary_angle
// Converts a signed (x, z) direction vector into an 8-bit binary angle,
// 256 units per turn, counterclockwise from positive x, truncated toward zero.
// ----------------------------------------------------------------------------
// Takes one vector per clock while the skid register is empty and returns one
// heading per vector, in order. A request passes 65 register stages before
// its response is valid: one sign and octant stage, a chain of 31 bin cells
// of two stages each (a constant multiply stage and a cross product compare
// stage), one unfold stage and the output register. A skid register lets the
// chain keep moving for one transaction while the response side stalls.
// ----------------------------------------------------------------------------
module heading_to_binary_angle #(
   parameter int COORD_WIDTH = htba_pkg::DEFAULT_COORD_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // x_coord, z_coord, zero padding to whole bytes
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // heading
   output logic [7:0]                           rsp_tdata
);
   import htba_pkg::*;

   logic                   advance;
   logic                   chain_valid [CELL_COUNT+1];
   ctrl_type               chain_ctrl  [CELL_COUNT+1];
   logic [COORD_WIDTH-1:0] chain_a     [CELL_COUNT+1];
   logic [COORD_WIDTH-1:0] chain_b     [CELL_COUNT+1];

   assign req_tready = advance;

   htba_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .x_coord  (req_tdata[COORD_WIDTH-1:0]),
      .z_coord  (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .out_valid(chain_valid[0]),
      .out_ctrl (chain_ctrl[0]),
      .out_a    (chain_a[0]),
      .out_b    (chain_b[0])
   );

   for (genvar k = 1; k <= CELL_COUNT; k++) begin : g_cell
      htba_cell #(
         .COORD_WIDTH(COORD_WIDTH),
         .BIN_INDEX  (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (chain_valid[k-1]),
         .in_ctrl  (chain_ctrl[k-1]),
         .in_a     (chain_a[k-1]),
         .in_b     (chain_b[k-1]),
         .out_valid(chain_valid[k]),
         .out_ctrl (chain_ctrl[k]),
         .out_a    (chain_a[k]),
         .out_b    (chain_b[k])
      );
   end

   htba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CELL_COUNT]),
      .in_ctrl   (chain_ctrl[CELL_COUNT]),
      .advance   (advance),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ test/heading_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_checker
// Watches the request and response streams of the heading converter. Each
// accepted request is run through an integer bin predictor and queued, and
// each accepted response is compared with the oldest queued heading.
// ----------------------------------------------------------------------------
module heading_checker #(
   parameter int CW = htba_pkg::DEFAULT_COORD_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // x_coord, z_coord, zero padding to whole bytes
   input  logic [((2*CW+7)/8)*8-1:0]          req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // heading
   input  logic [7:0]                         rsp_tdata,
   output int                                 errors,
   output int                                 backlog
);
   import htba_pkg::*;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] z;
      logic [7:0]    heading;
   } heading_due_type;

   heading_due_type  headings_due[$];
   heading_due_type  oldest;
   logic [TAB_W-1:0] cos_q [BIN_COUNT];
   logic [TAB_W-1:0] sin_q [BIN_COUNT];

   function automatic logic [TAB_W-1:0] q62_mul(input logic [TAB_W-1:0] a,
                                               input logic [TAB_W-1:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[125:62] + {63'b0, p[61]};
   endfunction

   function automatic logic [TAB_W-1:0] q62_sqrt(input logic [TAB_W-1:0] v);
      logic [127:0]     target;
      logic [127:0]     sq;
      logic [TAB_W-1:0] root;
      logic [TAB_W-1:0] trial;
      target = {64'b0, v} << 62;
      root   = '0;
      for (int b = 62; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         sq    = {64'b0, trial} * {64'b0, trial};
         if (sq <= target) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // floor of atan2(a, b) in binary angle units, for 0 <= a <= b, b > 0
   function automatic logic [5:0] sector_bin(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [5:0]   n;
      logic         stop;
      n    = '0;
      stop = 1'b0;
      if (a == b) begin
         return OCTANT_EDGE;
      end
      for (int k = 1; k < BIN_COUNT; k++) begin
         lhs = {{(128-CW){1'b0}}, a} * {64'b0, cos_q[k]};
         rhs = {{(128-CW){1'b0}}, b} * {64'b0, sin_q[k]};
         if (!stop) begin
            if (lhs >= rhs) begin
               n = k[5:0];
            end else begin
               stop = 1'b1;
            end
         end
      end
      return n;
   endfunction

   function automatic logic [7:0] predict_heading(input logic [CW-1:0] xr,
                                                  input logic [CW-1:0] zr);
      logic          xneg;
      logic          zneg;
      logic [CW-1:0] u;
      logic [CW-1:0] w;
      logic [5:0]    f;
      logic [7:0]    m;
      xneg = xr[CW-1];
      zneg = zr[CW-1];
      u = xneg ? (~xr + 1'b1) : xr;
      w = zneg ? (~zr + 1'b1) : zr;
      if (u == '0) begin
         return (!zneg && w != '0) ? HEADING_POS_Z : HEADING_NEG_Z;
      end
      if (w <= u) begin
         f = sector_bin(w, u);
      end else begin
         f = QUADRANT_MAX - sector_bin(u, w);
      end
      if (xneg) begin
         m = (w == '0 || w == u) ? HALF_TURN - {2'b0, f} : HALF_TURN_M1 - {2'b0, f};
      end else begin
         m = {2'b0, f};
      end
      return zneg ? (8'd0 - m) : m;
   endfunction

   task automatic report_mismatch(input string what, input logic [CW-1:0] x,
                                  input logic [CW-1:0] z, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t ns: %s x=%0d z=%0d got=%0d expected=%0d", $time, what,
               $signed(x), $signed(z), got, want);
      errors++;
   endtask

   initial begin
      logic [TAB_W-1:0] c;
      logic [TAB_W-1:0] c1;
      logic [TAB_W-1:0] s1;
      errors  = 0;
      backlog = 0;
      c = '0;
      for (int i = 0; i < 5; i++) begin
         c = q62_sqrt((ONE_Q + c) >> 1);
      end
      c1 = q62_sqrt((ONE_Q + c) >> 1);
      s1 = q62_sqrt((ONE_Q - c) >> 1);
      cos_q[0] = ONE_Q;
      sin_q[0] = '0;
      cos_q[1] = c1;
      sin_q[1] = s1;
      for (int i = 2; i < BIN_COUNT; i++) begin
         cos_q[i] = q62_mul(cos_q[i-1], c1) - q62_mul(sin_q[i-1], s1);
         sin_q[i] = q62_mul(sin_q[i-1], c1) + q62_mul(cos_q[i-1], s1);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (headings_due.size() == 0) begin
               report_mismatch("unexpected response", '0, '0, rsp_tdata, 8'd0);
            end else begin
               oldest = headings_due.pop_front();
               if (rsp_tdata !== oldest.heading) begin
                  report_mismatch("heading mismatch", oldest.x, oldest.z, rsp_tdata,
                                  oldest.heading);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            oldest.x       = req_tdata[CW-1:0];
            oldest.z       = req_tdata[2*CW-1:CW];
            oldest.heading = predict_heading(oldest.x, oldest.z);
            headings_due.push_back(oldest);
         end
         backlog = headings_due.size();
      end
   end

endmodule

@@ test/heading_to_binary_angle_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_to_binary_angle_tb
// Drives direction vectors into the heading converter: directed extremes and
// axis, diagonal and near-zero cases, then random vectors of several shapes,
// with random idling on both streams, a long response hold-off that backs up
// the pipeline, and a final stretch at full rate. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module heading_to_binary_angle_tb;
   import htba_pkg::*;

   localparam int CW        = DEFAULT_COORD_WIDTH;
   localparam int DW        = ((2*CW+7)/8)*8;
   localparam int LATENCY   = 65;
   localparam int HOLD_LEN  = 300;
   localparam int LIMIT     = 300000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [DW-1:0] req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [7:0]    rsp_tdata;
   int            errors;
   int            backlog;
   int            cycle_count;
   bit            idle_on;
   bit            hold_request;

   heading_to_binary_angle #(.COORD_WIDTH(CW)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   heading_checker #(.CW(CW)) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .errors     (errors),
      .backlog    (backlog)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("FAIL heading_to_binary_angle");
         $finish;
      end
   end

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_LEN;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (run_left > 0) begin
               run_left--;
            end else if (idle_on) begin
               if ($urandom_range(0, 2) == 0) begin
                  stall_left = $urandom_range(1, 13);
               end else begin
                  run_left = $urandom_range(0, 20);
               end
            end
         end
      end
   end

   task automatic send_vector(input logic [CW-1:0] x, input logic [CW-1:0] z);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {z, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_all_returned();
      while (backlog != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic [CW-1:0] x;
      logic [CW-1:0] z;
      logic [CW-1:0] edge_vals [6];
      int            kind;
      edge_vals = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         x = CW'($urandom);
         z = CW'($urandom);
         unique case (kind)
            4: begin
               x = CW'($urandom_range(0, 16) - 8);
               z = CW'($urandom_range(0, 16) - 8);
            end
            5: begin
               if ($urandom_range(0, 1)) x = '0;
               else z = '0;
            end
            6: begin
               z = ($urandom_range(0, 1) ? x : -x) + CW'($urandom_range(0, 4) - 2);
            end
            7: begin
               z = CW'($urandom_range(0, 8) - 4);
            end
            8: begin
               x = edge_vals[3'($urandom_range(0, 5))];
               z = edge_vals[3'($urandom_range(0, 5))];
            end
            9: begin
               x = CW'($urandom_range(0, 8) - 4);
            end
            default: begin
            end
         endcase
         send_vector(x, z);
      end
   endtask

   initial begin
      idle_on      = 1'b1;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_vector(16'h7FFF, 16'h0000);
      send_vector(16'h8000, 16'h0000);
      send_vector(16'h0000, 16'h7FFF);
      send_vector(16'h0000, 16'h8000);
      send_vector(16'h0000, 16'h0000);
      send_vector(16'h7FFF, 16'h7FFF);
      send_vector(16'h8000, 16'h8000);
      send_vector(16'h8000, 16'h7FFF);
      send_vector(16'h7FFF, 16'h8000);
      send_vector(-16'sd5, 16'sd5);
      send_vector(16'sd5, -16'sd5);
      send_vector(-16'sd5, -16'sd5);
      send_vector(16'sd1, 16'sd0);
      send_vector(-16'sd1, 16'sd0);
      send_vector(16'sd0, 16'sd1);
      send_vector(16'sd0, -16'sd1);
      send_vector(16'sd1, -16'sd1);
      send_vector(16'h7FFF, -16'sd1);
      send_vector(16'h7FFF, -16'sd300);
      send_vector(16'h8000, 16'sd1);
      send_vector(16'h8000, -16'sd1);
      send_vector(16'sd100, 16'sd41);
      send_vector(-16'sd1, 16'h7FFF);
      send_vector(16'hFFFF, 16'hFFFF);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_all_returned();

      send_random(250);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_all_returned();

      // back up the pipeline while requests keep coming
      hold_request = 1'b1;
      idle_on      = 1'b0;
      send_random(150);
      @(negedge clock);
      req_tvalid <= 1'b0;
      idle_on = 1'b1;
      wait_all_returned();

      idle_on = 1'b0;
      send_random(100);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_all_returned();

      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && backlog == 0) begin
         $display("PASS heading_to_binary_angle");
      end else begin
         $display("FAIL heading_to_binary_angle");
      end
      $finish;
   end

endmodule
